// File: src/value_list_insert_remove_top_assert.svh
// ---------------------------------------------------------------------------
// value_list_insert_remove_top_assert.svh
// Assertion macros shared by the list checker.
// ---------------------------------------------------------------------------
`ifndef VALUE_LIST_INSERT_REMOVE_TOP_ASSERT_SVH
`define VALUE_LIST_INSERT_REMOVE_TOP_ASSERT_SVH

// Property that must hold in every cycle outside reset
`define VLIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent
`define VLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vlir_pkg.sv
// ---------------------------------------------------------------------------
// vlir_pkg
// Shared types and constants of the ordered value list.
// ---------------------------------------------------------------------------
package vlir_pkg;

    // Default number of list entries
    localparam int DEPTH_DEF = 16;
    // Width of one stored value
    localparam int DATA_W = 32;

    // Operation codes carried by the func field
    typedef enum logic [1:0] {
        FN_INSERT    = 2'd0,
        FN_REM_FIRST = 2'd1,
        FN_REM_ALL   = 2'd2,
        FN_DUMP      = 2'd3
    } func_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic ins;   // shift toward the tail, head cell takes the new value
        logic step;  // shift toward the head, head entry goes around
        logic keep;  // head entry is appended at the tail on this step
    } cell_ctl_t;

endpackage

// File: src/vlir_cell.sv
// ---------------------------------------------------------------------------
// vlir_cell
// One list slot: holds a value and moves it to or from its neighbors.
// ---------------------------------------------------------------------------
module vlir_cell
    import vlir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
)
(
    input  logic                                clk,
    input  cell_ctl_t                           ctl,
    input  logic [$clog2(DEPTH + 1) - 1:0]      cnt,
    input  logic signed [DATA_W - 1:0]          left_in,
    input  logic signed [DATA_W - 1:0]          right_in,
    input  logic signed [DATA_W - 1:0]          head_in,
    output logic signed [DATA_W - 1:0]          data
);

    localparam int CW = $clog2(DEPTH + 1);
    // This cell is the tail when the count is one past its index
    localparam logic [CW - 1:0] TAIL_CNT = CW'(INDEX + 1);

    logic signed [DATA_W - 1:0] data_reg;
    logic signed [DATA_W - 1:0] data_next;
    logic                       tail_sel;

    assign tail_sel = (cnt == TAIL_CNT);

    // Next value: insert shift, rotate step with tail append, or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            data_next = left_in;
        end
        else if (ctl.step)
        begin
            if (ctl.keep && tail_sel)
                data_next = head_in;
            else
                data_next = right_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: src/value_list_insert_remove_top.sv
// ---------------------------------------------------------------------------
// value_list_insert_remove_top
// Bounded ordered list of signed values built as a row of shifting cells.
// ---------------------------------------------------------------------------
// An insert shifts the row toward the tail and the head cell takes the value.
// Remove-first, remove-all and dump take the command and then make one step
// per entry held: the row rotates toward the head, the head entry is compared
// against the value and either appended back at the tail or dropped, so the
// row compacts itself as it goes. A dump emits one item per rotation step,
// head first, and a step waits while the result register is held by a
// stalled item. An operation on an empty list makes no steps and answers with
// a single item. A new command is taken once the previous one has finished
// and the result register is free or being emptied.
// ---------------------------------------------------------------------------
module value_list_insert_remove_top
    import vlir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [1:0]                          func,
    input  logic signed [DATA_W - 1:0]          value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic signed [DATA_W - 1:0]          data,
    output logic                                ok,
    output logic                                last,
    output logic [$clog2(DEPTH + 1) - 1:0]      count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW - 1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW - 1:0] ONE_CNT  = CW'(1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                     state_reg, state_next;
    func_t                      func_reg, func_next;
    logic signed [DATA_W - 1:0] value_reg, value_next;
    logic [CW - 1:0]            cnt_reg, cnt_next;
    logic [CW - 1:0]            left_reg, left_next;
    logic                       hit_reg, hit_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic signed [DATA_W - 1:0] rsp_data_reg, rsp_data_next;
    logic                       rsp_ok_reg, rsp_ok_next;
    logic                       rsp_last_reg, rsp_last_next;
    logic [CW - 1:0]            rsp_count_reg, rsp_count_next;

    logic signed [DATA_W - 1:0] cell_data [DEPTH];
    cell_ctl_t                  ctl;
    func_t                      cmd_func;
    logic                       rsp_free;
    logic                       cmd_fire;
    logic                       match;
    logic                       drop;
    logic                       last_step;
    logic                       emits;
    logic                       step_go;

    assign cmd_func  = func_t'(func);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && rsp_free;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Head compare and step decision
    assign match     = (cell_data[0] == value_reg);
    assign drop      = ((func_reg == FN_REM_FIRST) && match && !hit_reg) ||
                       ((func_reg == FN_REM_ALL) && match);
    assign last_step = (left_reg == ONE_CNT);
    assign emits     = (func_reg == FN_DUMP) || last_step;
    assign step_go   = (state_reg == ST_RUN) && (!emits || rsp_free);

    // Control broadcast to the cell row
    always_comb
    begin
        ctl.ins  = cmd_fire && (cmd_func == FN_INSERT) && (cnt_reg != FULL_CNT);
        ctl.step = step_go;
        ctl.keep = !drop;
    end

    // Cell row: entry 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W - 1:0] left_in;
        logic signed [DATA_W - 1:0] right_in;

        if (i == 0)
        begin : g_head
            assign left_in = value;
        end
        else
        begin : g_mid
            assign left_in = cell_data[i - 1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_in = cell_data[0];
        end
        else
        begin : g_body
            assign right_in = cell_data[i + 1];
        end

        vlir_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .cnt      (cnt_reg),
            .left_in  (left_in),
            .right_in (right_in),
            .head_in  (cell_data[0]),
            .data     (cell_data[i])
        );
    end

    // Sequencer and result register next state
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        value_next     = value_reg;
        cnt_next       = cnt_reg;
        left_next      = left_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_last_next  = rsp_last_reg;
        rsp_count_next = rsp_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd_func == FN_INSERT)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_data_next  = '0;
                        rsp_last_next  = 1'b1;
                        if (cnt_reg != FULL_CNT)
                        begin
                            cnt_next       = cnt_reg + ONE_CNT;
                            rsp_ok_next    = 1'b1;
                            rsp_count_next = cnt_reg + ONE_CNT;
                        end
                        else
                        begin
                            rsp_ok_next    = 1'b0;
                            rsp_count_next = cnt_reg;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        // Empty list: single refusal item
                        rsp_valid_next = 1'b1;
                        rsp_data_next  = '0;
                        rsp_ok_next    = 1'b0;
                        rsp_last_next  = 1'b1;
                        rsp_count_next = '0;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        func_next  = cmd_func;
                        value_next = value;
                        left_next  = cnt_reg;
                        hit_next   = 1'b0;
                    end
                end
            end
            ST_RUN:
            begin
                if (step_go)
                begin
                    left_next = left_reg - ONE_CNT;
                    hit_next  = hit_reg || drop;
                    cnt_next  = cnt_reg - CW'(drop);
                    if (func_reg == FN_DUMP)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_data_next  = cell_data[0];
                        rsp_ok_next    = 1'b1;
                        rsp_last_next  = last_step;
                        rsp_count_next = cnt_reg;
                    end
                    else if (last_step)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_data_next  = '0;
                        rsp_ok_next    = hit_reg || drop;
                        rsp_last_next  = 1'b1;
                        rsp_count_next = cnt_reg - CW'(drop);
                    end
                    if (last_step)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FN_INSERT;
            value_reg     <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
            rsp_ok_reg    <= 1'b0;
            rsp_last_reg  <= 1'b0;
            rsp_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            value_reg     <= value_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_ok_reg    <= rsp_ok_next;
            rsp_last_reg  <= rsp_last_next;
            rsp_count_reg <= rsp_count_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign data      = rsp_data_reg;
    assign ok        = rsp_ok_reg;
    assign last      = rsp_last_reg;
    assign count     = rsp_count_reg;

endmodule

// File: src/vlir_checker.sv
// ---------------------------------------------------------------------------
// vlir_checker
// Port-level checks of the ordered value list, bound to the top level.
// ---------------------------------------------------------------------------
`include "value_list_insert_remove_top_assert.svh"

module vlir_checker
    import vlir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [DATA_W - 1:0]          data,
    input  logic                                ok,
    input  logic                                last,
    input  logic [$clog2(DEPTH + 1) - 1:0]      count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW - 1:0] FULL_CNT = CW'(DEPTH);

    // Reported count never passes the capacity
    `VLIR_ASSERT_ALWAYS(a_count_range, !rsp_valid || (count <= FULL_CNT), "count above depth")

    // A command is only taken when the result slot can accept its item
    `VLIR_ASSERT_ALWAYS(a_ready_slot, !cmd_ready || !rsp_valid || rsp_ready, "ready with slot full")

    // Items ahead of the last one are dump entries and always valid
    `VLIR_ASSERT_ALWAYS(a_dump_ok, !rsp_valid || last || ok, "non-final item without ok")

    // A stalled item holds its data and count
    `VLIR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(data) && $stable(count), "stalled item changed")

endmodule

bind value_list_insert_remove_top vlir_checker #(.DEPTH(DEPTH)) u_vlir_checker (.*);
